// ----- hw/rtl/randomized_hadamard_transform_unit_macros.svh -----
// Assertion macros shared by the randomised Hadamard transform RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RANDOMIZED_HADAMARD_TRANSFORM_UNIT_MACROS_SVH
`define RANDOMIZED_HADAMARD_TRANSFORM_UNIT_MACROS_SVH
// Same-cycle implication
`define RHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define RHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/rht_pkg.sv -----
// Package for the randomised Hadamard transform unit: payload types,
// constants, Paley sign and scale helpers. No dependencies.
package rht_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_LEN_DEF = 64;
	localparam int CFG_W       = 64;
	localparam int OD_W        = 7;

	// register indexes
	localparam logic REG_SEED     = 1'b0;
	localparam logic REG_OUT_DIMS = 1'b1;

	// splitmix64 constants
	localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX1  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX2  = 64'h94D0_49BB_1331_11EB;

	// quadratic residue masks for p = 11 and p = 19 (bit d set: d is a residue)
	localparam logic [19:0] QR11 = 20'h0023A;
	localparam logic [19:0] QR19 = 20'h30AF2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIMS = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
		logic                          is_empty;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last_out;
		status_t                       status;
	} out_t;

	// Paley type I entry sign, true for -1; m20 picks m = 20, else m = 12
	function automatic logic paley_neg(logic [4:0] i, logic [4:0] j, logic m20);
		logic [4:0] p;
		logic [4:0] a;
		logic [4:0] b;
		logic [5:0] d;
		logic       res;
		p = m20 ? 5'd19 : 5'd11;
		a = i - 5'd1;
		b = j - 5'd1;
		d = {1'b0, a} + {1'b0, p} - {1'b0, b};
		if (d >= {1'b0, p})
			d = d - {1'b0, p};
		if (i == 5'd0)
			res = 1'b0;
		else if (j == 5'd0)
			res = 1'b1;
		else if (a == b)
			res = 1'b0;
		else
			res = m20 ? !QR19[d[4:0]] : !QR11[d[4:0]];
		return res;
	endfunction

	// nearest integer to 65536/sqrt(k); elaboration only
	function automatic logic [16:0] scale_for(longint k);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid * k <= (64'd1 << 32))
				lo = mid;
			else
				hi = mid - 1;
		end
		if ((2 * lo + 1) * (2 * lo + 1) * k < (64'd1 << 34))
			lo = lo + 1;
		return 17'(lo);
	endfunction

endpackage

// ----- hw/rtl/rht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rht_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/randomized_hadamard_transform_unit.sv -----
// Loading: each sample is accepted, then takes six 32x32 multiplier steps
// of the splitmix64 sign draw; busy stays high meanwhile.
// After the last sample: zero padding up to w, Paley blocks when w is 12 or 20 times
// a power of two, butterflies on the work RAM, then each result read, scaled, emitted.
// Results are single-cycle strobes and cannot be stalled.
// arst_n clears control, count and configuration; the work RAM is not cleared.
// Top level of the randomised Hadamard transform unit.
// Depends on rht_pkg, rht_ram and randomized_hadamard_transform_unit_macros.svh.
`include "randomized_hadamard_transform_unit_macros.svh"

module randomized_hadamard_transform_unit #(
	parameter int MAX_LEN = rht_pkg::MAX_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  rht_pkg::in_t             req,
	input  logic                     cfg_we,
	input  logic                     cfg_idx,
	input  logic [rht_pkg::CFG_W-1:0] cfg_data,
	output logic                     strobe,
	output rht_pkg::out_t            res
);
	import rht_pkg::*;

	localparam int LW   = $clog2(MAX_LEN + 1);
	localparam int AW   = $clog2(2 * MAX_LEN);
	localparam int MAXP = $clog2(MAX_LEN);
	localparam int DW   = SAMPLE_BITS + MAXP + 2;
	localparam int PW   = DW + 18;

	localparam logic signed [PW-1:0] VMAX = PW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] VMIN = -VMAX - PW'(1);
	localparam logic signed [PW-1:0] RND  = PW'(32768);

	typedef logic [16:0] scale_tab_t [0:MAX_LEN];

	function automatic scale_tab_t build_scale();
		scale_tab_t t;
		t[0] = '0;
		for (int k = 1; k <= MAX_LEN; k++)
			t[k] = scale_for(longint'(k));
		return t;
	endfunction

	localparam scale_tab_t SCALE_TAB = build_scale();

	typedef enum logic [3:0] {
		S_IDLE, S_MIX, S_FIN, S_PAD, S_XF, S_PRD, S_PACC, S_PWR,
		S_BINIT, S_BRU, S_BRV, S_BWU, S_BWV, S_ORD, S_OMUL, S_OEMIT
	} state_t;

	state_t                 state_q;
	logic [63:0]            seed_q;
	logic [OD_W-1:0]        od_q;
	logic [LW-1:0]          count_q;
	logic                   ovf_q;
	logic [63:0]            prng_q;
	logic [63:0]            z_q;
	logic [63:0]            acc_q;
	logic [1:0]             mcnt_q;
	logic                   mix2_q;
	logic signed [DW-1:0]   smp_q;
	logic                   lastin_q;
	logic [LW-1:0]          w_q;
	logic [LW-1:0]          k_q;
	logic [16:0]            sc_q;
	logic                   m20_q;
	logic                   kron_q;
	logic [LW-1:0]          idx_q;
	logic [LW-1:0]          cpos_q;
	logic [LW:0]            str_q;
	logic                   base_q;
	logic [4:0]             pi_q;
	logic [4:0]             pj_q;
	logic [LW-1:0]          boff_q;
	logic signed [DW-1:0]   pacc_q;
	logic signed [DW-1:0]   u_q;
	logic signed [DW-1:0]   v_q;
	logic signed [PW-1:0]   prod_s1;
	logic [LW-1:0]          oi_q;
	logic                   strobe_q;
	out_t                   res_q;

	// RAM port
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [DW-1:0]          ram_rdata;
	logic signed [DW-1:0]   rd_s;

	rht_ram #(
		.WIDTH(DW),
		.DEPTH(2 * MAX_LEN)
	) u_work (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_s   = $signed(ram_rdata);
	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign res    = res_q;

	// shared 32x32 multiplier for the splitmix64 mixing steps
	logic [63:0] mix_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] acc_nx;
	logic        sign_neg;

	always_comb begin
		mix_c  = mix2_q ? MIX2 : MIX1;
		mul_a  = (mcnt_q == 2'd2) ? z_q[63:32] : z_q[31:0];
		mul_b  = (mcnt_q == 2'd1) ? mix_c[63:32] : mix_c[31:0];
		mul_p  = {32'b0, mul_a} * {32'b0, mul_b};
		acc_nx = (mcnt_q == 2'd0) ? mul_p : acc_q + {mul_p[31:0], 32'b0};
		sign_neg = acc_nx[63];
	end

	// next stream state at a sample's arrival
	logic [63:0] prng_nx;
	assign prng_nx = ((count_q == '0) ? seed_q : prng_q) + GAMMA;

	// finish decisions: working length, Kronecker kind, kept count
	int   wp_i;
	int   w_i;
	int   kk_i;
	logic is12;
	logic is20;
	logic dims_bad;

	always_comb begin
		wp_i = MAX_LEN;
		is12 = 1'b0;
		is20 = 1'b0;
		for (int j = MAXP; j >= 0; j--) begin
			if ((1 << j) >= int'(count_q))
				wp_i = 1 << j;
		end
		for (int j = 0; j <= MAXP; j++) begin
			if (int'(count_q) == 12 * (1 << j))
				is12 = 1'b1;
			if (int'(count_q) == 20 * (1 << j))
				is20 = 1'b1;
		end
		w_i      = (is12 || is20) ? int'(count_q) : wp_i;
		kk_i     = (od_q == '0) ? w_i : int'(od_q);
		dims_bad = kk_i > w_i;
	end

	// Paley and butterfly helpers
	logic [4:0]           m_val;
	logic                 pneg;
	logic signed [DW-1:0] pacc_nx;
	int                   base_i;
	logic [LW:0]          cpos_nx;
	logic [LW+1:0]        j_nx;

	always_comb begin
		m_val   = m20_q ? 5'd20 : 5'd12;
		pneg    = paley_neg(pi_q, pj_q, m20_q);
		pacc_nx = ((pj_q == 5'd0) ? '0 : pacc_q) + (pneg ? -rd_s : rd_s);
		base_i  = base_q ? MAX_LEN : 0;
		cpos_nx = {1'b0, cpos_q} + (LW+1)'(1);
		j_nx    = (LW+2)'(idx_q) + (LW+2)'(1);
		if (cpos_nx == str_q)
			j_nx = j_nx + (LW+2)'(str_q);
	end

	// output rounding and saturation
	logic signed [PW-1:0]          rnd;
	logic signed [SAMPLE_BITS-1:0] sat;

	always_comb begin
		rnd = (prod_s1 + RND) >>> 16;
		if (rnd > VMAX)
			sat = VMAX[SAMPLE_BITS-1:0];
		else if (rnd < VMIN)
			sat = VMIN[SAMPLE_BITS-1:0];
		else
			sat = rnd[SAMPLE_BITS-1:0];
	end

	// work RAM addressing per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_MIX: begin
				ram_we    = mix2_q && (mcnt_q == 2'd2);
				ram_waddr = AW'(count_q);
				ram_wdata = sign_neg ? -smp_q : smp_q;
			end
			S_PAD: begin
				ram_we    = idx_q < w_q;
				ram_waddr = AW'(idx_q);
			end
			S_PRD: ram_raddr = AW'(int'(boff_q) + int'(pj_q));
			S_PWR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(MAX_LEN + int'(boff_q) + int'(pi_q));
				ram_wdata = pacc_q;
			end
			S_BRU: ram_raddr = AW'(base_i + int'(idx_q));
			S_BRV: ram_raddr = AW'(base_i + int'(idx_q) + int'(str_q));
			S_BWU: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(base_i + int'(idx_q));
				ram_wdata = u_q + rd_s;
			end
			S_BWV: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(base_i + int'(idx_q) + int'(str_q));
				ram_wdata = u_q - v_q;
			end
			S_ORD: ram_raddr = AW'(base_i + int'(oi_q));
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			seed_q   <= '0;
			od_q     <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			prng_q   <= '0;
			mcnt_q   <= '0;
			mix2_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SEED:     seed_q <= cfg_data;
					REG_OUT_DIMS: od_q   <= cfg_data[OD_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.is_empty) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else if (int'(count_q) >= MAX_LEN) begin
							ovf_q <= 1'b1;
							if (req.last)
								state_q <= S_FIN;
						end else begin
							smp_q    <= {{(DW-SAMPLE_BITS){req.sample[SAMPLE_BITS-1]}},
								req.sample};
							lastin_q <= req.last;
							prng_q   <= prng_nx;
							z_q      <= prng_nx ^ (prng_nx >> 30);
							mcnt_q   <= '0;
							mix2_q   <= 1'b0;
							state_q  <= S_MIX;
						end
					end
				end
				S_MIX: begin
					acc_q <= acc_nx;
					if (mcnt_q == 2'd2) begin
						mcnt_q <= '0;
						if (mix2_q) begin
							count_q <= count_q + LW'(1);
							state_q <= lastin_q ? S_FIN : S_IDLE;
						end else begin
							z_q    <= acc_nx ^ (acc_nx >> 27);
							mix2_q <= 1'b1;
						end
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				S_FIN: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					w_q     <= LW'(w_i);
					k_q     <= LW'(kk_i);
					sc_q    <= SCALE_TAB[LW'(kk_i)];
					m20_q   <= is20;
					kron_q  <= is12 || is20;
					idx_q   <= count_q;
					if (ovf_q || dims_bad) begin
						res_q.value    <= '0;
						res_q.last_out <= 1'b1;
						res_q.status   <= ovf_q ? ST_OVF : ST_DIMS;
						strobe_q       <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (idx_q < w_q)
						idx_q <= idx_q + LW'(1);
					else
						state_q <= S_XF;
				end
				S_XF: begin
					pi_q   <= '0;
					pj_q   <= '0;
					boff_q <= '0;
					str_q  <= (LW+1)'(1);
					base_q <= 1'b0;
					state_q <= kron_q ? S_PRD : S_BINIT;
				end
				S_PRD: state_q <= S_PACC;
				S_PACC: begin
					pacc_q <= pacc_nx;
					if (pj_q == m_val - 5'd1) begin
						state_q <= S_PWR;
					end else begin
						pj_q    <= pj_q + 5'd1;
						state_q <= S_PRD;
					end
				end
				S_PWR: begin
					pj_q <= '0;
					if (pi_q == m_val - 5'd1) begin
						pi_q   <= '0;
						boff_q <= boff_q + LW'(m_val);
						if (boff_q + LW'(m_val) == w_q) begin
							str_q   <= (LW+1)'(m_val);
							base_q  <= 1'b1;
							state_q <= S_BINIT;
						end else begin
							state_q <= S_PRD;
						end
					end else begin
						pi_q    <= pi_q + 5'd1;
						state_q <= S_PRD;
					end
				end
				S_BINIT: begin
					idx_q  <= '0;
					cpos_q <= '0;
					oi_q   <= '0;
					state_q <= (str_q >= {1'b0, w_q}) ? S_ORD : S_BRU;
				end
				S_BRU: state_q <= S_BRV;
				S_BRV: begin
					u_q     <= rd_s;
					state_q <= S_BWU;
				end
				S_BWU: begin
					v_q     <= rd_s;
					state_q <= S_BWV;
				end
				S_BWV: begin
					cpos_q <= (cpos_nx == str_q) ? '0 : cpos_nx[LW-1:0];
					idx_q  <= j_nx[LW-1:0];
					if (j_nx >= (LW+2)'(w_q)) begin
						str_q   <= str_q << 1;
						state_q <= S_BINIT;
					end else begin
						state_q <= S_BRU;
					end
				end
				S_ORD: state_q <= S_OMUL;
				S_OMUL: begin
					prod_s1 <= PW'(rd_s) * $signed({1'b0, sc_q});
					state_q <= S_OEMIT;
				end
				S_OEMIT: begin
					res_q.value    <= sat;
					res_q.last_out <= (oi_q + LW'(1) == k_q);
					res_q.status   <= ST_OK;
					strobe_q       <= 1'b1;
					if (oi_q + LW'(1) == k_q) begin
						state_q <= S_IDLE;
					end else begin
						oi_q    <= oi_q + LW'(1);
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RHT_ASSERT_NXT(a_strobe_single, strobe, !strobe, "result strobes back to back")
	`RHT_ASSERT_IMP(a_last_to_idle, strobe && res.last_out, !busy, "not idle at final result")
	`RHT_ASSERT_IMP(a_error_is_last, strobe && res.status != ST_OK, res.last_out, "error result not last")
	`RHT_ASSERT_IMP(a_count_bound, 1'b1, int'(count_q) <= MAX_LEN, "element count beyond capacity")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for randomized_hadamard_transform_unit: directed table, then random
// vectors against an in-bench sign/Hadamard/scale predictor. Depends on rht_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rht_pkg::*;

	typedef enum {ROW_SEED, ROW_DIMS, ROW_ITEM, ROW_VEC} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		logic [63:0] data;
		int          sample;
		bit          last;
		bit          empty;
		bit          typed;
		status_t     tstat;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         req;
	logic        cfg_we;
	logic        cfg_idx;
	logic [63:0] cfg_data;
	logic        strobe;
	out_t        res;

	// predictor state
	logic [63:0] p_seed;
	logic [6:0]  p_dims;
	longint      acc_buf [0:127];
	int          fill;
	logic [63:0] draw_state;
	bit          dropped;
	out_t        fresh_q[$];
	out_t        coord_q[$];

	int errs, n_items, n_vecs, n_res, n_phases;
	bit calm;
	row_t rows[$];

	randomized_hadamard_transform_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.strobe(strobe), .res(res)
	);

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	initial begin
		#20ms;
		$display("tb_top: errors");
		$finish;
	end

	// splitmix64 step of the sign stream
	function automatic logic [63:0] sign_draw();
		logic [63:0] z;
		draw_state = draw_state + GAMMA;
		z = draw_state;
		z = (z ^ (z >> 30)) * MIX1;
		z = (z ^ (z >> 27)) * MIX2;
		return z ^ (z >> 31);
	endfunction

	function automatic bit pow2(int v);
		return v != 0 && (v & (v - 1)) == 0;
	endfunction

	// nearest integer to 65536/sqrt(k)
	function automatic longint gain_for(longint k);
		longint g;
		g = longint'($sqrt(4294967296.0 / k));
		while (g * g * k > 64'sd4294967296) g--;
		while ((g + 1) * (g + 1) * k <= 64'sd4294967296) g++;
		if ((2 * g + 1) * (2 * g + 1) * k < 64'sd17179869184) g++;
		return g;
	endfunction

	function automatic out_t fault(status_t st);
		out_t o;
		o.value = '0;
		o.last_out = 1'b1;
		o.status = st;
		return o;
	endfunction

	// transform the loaded vector and queue its coordinates in fresh_q
	function automatic void transform_vec();
		int n, m, w, k, p, i, j, h, blk, lane, x;
		bit qr [0:19];
		longint z [0:19];
		longint a, u, v, g, r;
		bit neg;
		out_t o;
		n = fill;
		m = 0;
		if (dropped) begin
			fresh_q.push_back(fault(ST_OVF));
			return;
		end
		if (n % 12 == 0 && pow2(n / 12)) m = 12;
		else if (n % 20 == 0 && pow2(n / 20)) m = 20;
		if (m != 0) w = n;
		else begin
			w = 1;
			while (w < n) w = w * 2;
		end
		k = (p_dims != 0) ? int'(p_dims) : w;
		if (k > w) begin
			fresh_q.push_back(fault(ST_DIMS));
			return;
		end
		for (i = n; i < w; i++) acc_buf[i] = 0;
		if (m != 0) begin
			p = m - 1;
			for (i = 0; i < 20; i++) qr[i] = 0;
			for (x = 1; x < p; x++) qr[(x * x) % p] = 1;
			// Paley matrix on each block
			for (blk = 0; blk < n / m; blk++) begin
				for (i = 0; i < m; i++) begin
					a = 0;
					for (j = 0; j < m; j++) begin
						if (i == 0) neg = 0;
						else if (j == 0) neg = 1;
						else if (i == j) neg = 0;
						else neg = !qr[((i - 1) + p - (j - 1)) % p];
						a = neg ? a - acc_buf[blk * m + j] : a + acc_buf[blk * m + j];
					end
					z[i] = a;
				end
				for (i = 0; i < m; i++) acc_buf[blk * m + i] = z[i];
			end
			// butterflies across blocks
			for (h = 1; h < n / m; h = h * 2)
				for (i = 0; i < n / m; i += 2 * h)
					for (j = i; j < i + h; j++)
						for (lane = 0; lane < m; lane++) begin
							u = acc_buf[j * m + lane];
							v = acc_buf[(j + h) * m + lane];
							acc_buf[j * m + lane] = u + v;
							acc_buf[(j + h) * m + lane] = u - v;
						end
		end else begin
			for (h = 1; h < w; h = h * 2)
				for (i = 0; i < w; i += 2 * h)
					for (j = i; j < i + h; j++) begin
						u = acc_buf[j];
						v = acc_buf[j + h];
						acc_buf[j] = u + v;
						acc_buf[j + h] = u - v;
					end
		end
		g = gain_for(k);
		for (i = 0; i < k; i++) begin
			r = (acc_buf[i] * g + 32768) >>> 16;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			o.value = 16'(r);
			o.last_out = (i + 1 == k);
			o.status = ST_OK;
			fresh_q.push_back(o);
		end
	endfunction

	// model one accepted request; results land in fresh_q
	function automatic void predict(in_t it);
		longint v;
		logic [63:0] d;
		fresh_q.delete();
		if (it.is_empty) begin
			fill = 0;
			dropped = 0;
			return;
		end
		if (fill >= 64) dropped = 1;
		else begin
			v = longint'(it.sample);
			if (fill == 0) draw_state = p_seed;
			d = sign_draw();
			if (d[63]) v = -v;
			acc_buf[fill] = v;
			fill++;
		end
		if (!it.last) return;
		transform_vec();
		fill = 0;
		dropped = 0;
	endfunction

	// call at a rising edge; returns at the edge that accepted the request
	task automatic put(in_t it, bit typed, status_t tstat);
		bit took;
		start <= 1'b1;
		req <= it;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
		n_items++;
		if (it.last && !it.is_empty) n_vecs++;
		predict(it);
		if (typed) coord_q.push_back(fault(tstat));
		else foreach (fresh_q[i]) coord_q.push_back(fresh_q[i]);
	endtask

	task automatic hold_off(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
	endtask

	// wait for every expected coordinate and an idle block
	task automatic drain();
		bit done;
		start <= 1'b0;
		do begin
			@(negedge clk);
			done = coord_q.size() == 0 && !busy;
			@(posedge clk);
		end while (!done);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_SEED) p_seed = data;
		else p_dims = data[6:0];
	endtask

	task automatic send_vec(int len, bit rnd, bit typed, status_t tstat);
		in_t it;
		for (int i = 0; i < len; i++) begin
			it.sample = rnd ? 16'($urandom) : ((i % 2) ? -16'sd32768 : 16'sd32767);
			it.last = (i == len - 1);
			it.is_empty = 1'b0;
			put(it, typed && it.last, tstat);
			maybe_gap();
		end
	endtask

	function automatic void add_row(row_kind_t kd, logic [63:0] data, int smp, bit lst,
			bit emp, bit typed, status_t st);
		row_t r;
		r.kind = kd; r.data = data; r.sample = smp; r.last = lst;
		r.empty = emp; r.typed = typed; r.tstat = st;
		rows.push_back(r);
	endfunction

	// check each coordinate strobe against the oldest expectation
	always @(negedge clk) begin
		out_t e;
		if (arst_n && strobe) begin
			n_res++;
			if (coord_q.size() == 0) begin
				$error("unexpected result: value %0d status %0d", res.value, res.status);
				errs++;
			end else begin
				e = coord_q.pop_front();
				if (res.value !== e.value) begin
					$error("value: expected %0d, actual %0d", e.value, res.value);
					errs++;
				end
				if (res.last_out !== e.last_out) begin
					$error("last_out: expected %0d, actual %0d", e.last_out, res.last_out);
					errs++;
				end
				if (res.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, res.status);
					errs++;
				end
			end
		end
	end

	initial begin
		in_t it;
		int len, r, nv;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_SEED;
		cfg_data = '0;
		p_seed = '0;
		p_dims = '0;
		fill = 0;
		draw_state = '0;
		dropped = 0;
		errs = 0; n_items = 0; n_vecs = 0; n_res = 0; n_phases = 0;
		calm = 0;

		// directed table
		add_row(ROW_SEED, 64'd0, 0, 0, 0, 0, ST_OK);
		add_row(ROW_DIMS, 64'd0, 0, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, 32767, 1, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, -32768, 1, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, 0, 1, 1, 0, ST_OK);
		add_row(ROW_ITEM, 0, 100, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, -5, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, -1, 0, 1, 0, ST_OK);	// discards the partial vector
		add_row(ROW_ITEM, 0, 1, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, -1, 1, 0, 0, ST_OK);
		add_row(ROW_SEED, '1, 0, 0, 0, 0, ST_OK);
		add_row(ROW_VEC, 64'd3, 0, 0, 0, 0, ST_OK);	// zero padded to four
		add_row(ROW_VEC, 64'd12, 0, 0, 0, 0, ST_OK);
		add_row(ROW_DIMS, 64'd5, 0, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, 7, 0, 0, 0, ST_OK);
		add_row(ROW_ITEM, 0, 9, 1, 0, 1, ST_DIMS);
		add_row(ROW_DIMS, 64'd127, 0, 0, 0, 0, ST_OK);
		add_row(ROW_VEC, 64'd1, 0, 0, 0, 1, ST_DIMS);
		add_row(ROW_DIMS, 64'd64, 0, 0, 0, 0, ST_OK);
		add_row(ROW_VEC, 64'd65, 0, 0, 0, 1, ST_OVF);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_SEED: begin
					drain();
					write_reg(REG_SEED, rows[i].data);
				end
				ROW_DIMS: begin
					drain();
					write_reg(REG_OUT_DIMS, rows[i].data);
				end
				ROW_ITEM: begin
					it.sample = 16'(rows[i].sample);
					it.last = rows[i].last;
					it.is_empty = rows[i].empty;
					put(it, rows[i].typed, rows[i].tstat);
					maybe_gap();
				end
				default: send_vec(int'(rows[i].data), 0, rows[i].typed, rows[i].tstat);
			endcase
		end

		// random phases; each starts from an idle block
		while (n_items < 110) begin
			n_phases++;
			if (n_items >= 100) calm = 1;
			drain();
			r = $urandom_range(0, 5);
			write_reg(REG_SEED, (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom});
			r = $urandom_range(0, 9);
			if (r < 4) write_reg(REG_OUT_DIMS, 64'd0);
			else if (r < 7) write_reg(REG_OUT_DIMS, 64'($urandom_range(1, 8)));
			else if (r == 7) write_reg(REG_OUT_DIMS, 64'd64);
			else if (r == 8) write_reg(REG_OUT_DIMS, 64'($urandom_range(65, 127)));
			else write_reg(REG_OUT_DIMS, 64'($urandom_range(1, 64)));
			nv = $urandom_range(1, 3);
			for (int v = 0; v < nv; v++) begin
				if ($urandom_range(0, 9) == 0) begin
					it = in_t'(18'($urandom));
					it.is_empty = 1'b1;
					put(it, 0, ST_OK);
					maybe_gap();
				end
				r = $urandom_range(0, 19);
				if (r < 10) len = $urandom_range(1, 10);
				else if (r < 12) len = $urandom_range(0, 1) ? 12 : 24;
				else if (r < 14) len = $urandom_range(0, 1) ? 20 : 40;
				else if (r == 14) len = 48;
				else if (r < 18) len = $urandom_range(1, 64);
				else len = 0;
				if (len == 0) begin
					// broken vector: partial load then an empty marker
					for (int i = 0; i < $urandom_range(1, 6); i++) begin
						it.sample = 16'($urandom);
						it.last = 1'b0;
						it.is_empty = 1'b0;
						put(it, 0, ST_OK);
						maybe_gap();
					end
					it = in_t'(18'($urandom));
					it.is_empty = 1'b1;
					put(it, 0, ST_OK);
				end else begin
					send_vec(len, 1, 0, ST_OK);
				end
			end
		end

		// closing vector with no idling at all
		calm = 1;
		drain();
		write_reg(REG_OUT_DIMS, 64'd0);
		send_vec(12, 1, 0, ST_OK);

		drain();
		repeat (100) @(posedge clk);
		$display("covered: %0d vectors, %0d result strobes, %0d random phases", n_vecs, n_res,
			n_phases);
		if (errs == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rht_pkg.sv
hw/rtl/rht_ram.sv
hw/rtl/randomized_hadamard_transform_unit.sv
bench/tb_top.sv
